>>> hw/rtl/sorted_linked_list_table_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted linked-list table
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_LINKED_LIST_TABLE_TOP_ASSERT_SVH
`define SORTED_LINKED_LIST_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SLLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SLLT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define SLLT_ASSERT(label, prop, msg)

`define SLLT_NEVER(label, expr, msg)

`endif

`endif

>>> hw/rtl/sllt_pkg.sv
// ----------------------------------------------------------------------------
// sllt_pkg
// Constants, codes and types of the sorted linked-list table.
// ----------------------------------------------------------------------------
package sllt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LINK_W   = IDX_W + 1;
    localparam int STEP_W   = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int SLOT_W   = 6;

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(CAPACITY);

    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REINIT = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_LINK,
        S_INS_PREV,
        S_DEL_PREV,
        S_DEL_FREE,
        S_RESULT
    } state_t;

    // link of a slot that has not been written since reset or reinit
    function automatic logic [LINK_W-1:0] default_link(input logic [IDX_W-1:0] idx);
        return LINK_W'({1'b0, idx}) + LINK_W'(1);
    endfunction

endpackage

>>> hw/rtl/sorted_linked_list_table_top.sv
// ----------------------------------------------------------------------------
// sorted_linked_list_table_top
// Ascending linked list of signed keys over a fixed slot pool, with free chain.
// ----------------------------------------------------------------------------
// Command channel: command/key words with cmd_valid, cmd_stall. Result
// channel: status/slot words with res_valid, res_stall. One result word per
// command word, in order.
// One command is in work at a time; cmd_stall is high until its result is
// handed to the output register. The walk reads the key and link memories
// once per cycle, one list position per cycle.
// Search walks the list; insert then goes on through S_INS_LINK and S_INS_PREV,
// delete through S_DEL_PREV and S_DEL_FREE, unless the key is a duplicate or
// absent. A walk passes at most 64 list positions; reinit and pool-full go
// straight to the result state.
// Reset empties the list and chains every slot into the free chain at once;
// the block is idle after reset, so the first command can be taken straight away.
// A stalled result stays in the output register; the next finished result
// waits in its own state until the register frees, and no command is taken
// meanwhile.
// ----------------------------------------------------------------------------
`include "sorted_linked_list_table_top_assert.svh"

module sorted_linked_list_table_top
    import sllt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  logic [CMD_W-1:0]         command,
    input  logic signed [KEY_W-1:0]  key,
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [STAT_W-1:0]        status,
    output logic [SLOT_W-1:0]        slot
);

    state_t state_reg, state_next;

    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic signed [KEY_W-1:0]  key_reg, key_next;
    logic [LINK_W-1:0]        list_head_reg, list_head_next;
    logic [LINK_W-1:0]        free_head_reg, free_head_next;
    logic [LINK_W-1:0]        cur_reg, cur_next;
    logic [LINK_W-1:0]        prev_reg, prev_next;
    logic [LINK_W-1:0]        cur_link_reg, cur_link_next;
    logic [IDX_W-1:0]         node_reg, node_next;
    logic [STEP_W-1:0]        steps_reg, steps_next;
    logic [STAT_W-1:0]        rstat_reg, rstat_next;
    logic [SLOT_W-1:0]        rslot_reg, rslot_next;
    logic                     res_valid_reg, res_valid_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;

    logic [KEY_W-1:0]         key_mem [CAPACITY];
    logic [LINK_W-1:0]        link_mem [CAPACITY];
    logic                     link_set_reg [CAPACITY];

    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         rd_addr_q;
    logic [KEY_W-1:0]         key_q;
    logic [LINK_W-1:0]        link_q;
    logic                     link_ok_q;
    logic [LINK_W-1:0]        link_eff;

    logic                     lk_we;
    logic                     ky_we;
    logic [IDX_W-1:0]         wr_addr;
    logic [LINK_W-1:0]        lk_wd;
    logic                     clear_links;

    logic                     accept;
    logic                     cur_in;
    logic                     less;
    logic                     advance;
    logic                     hit;
    logic                     out_free;

    // ------------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ky_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (lk_we)
        begin
            link_mem[wr_addr] <= lk_wd;
        end
        key_q     <= key_mem[rd_addr];
        link_q    <= link_mem[rd_addr];
        rd_addr_q <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                link_set_reg[i] <= 1'b0;
            end
            link_ok_q <= 1'b0;
        end
        else
        begin
            if (clear_links)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    link_set_reg[i] <= 1'b0;
                end
            end
            else if (lk_we)
            begin
                link_set_reg[wr_addr] <= 1'b1;
            end
            link_ok_q <= link_set_reg[rd_addr];
        end
    end

    assign link_eff = link_ok_q ? link_q : default_link(rd_addr_q);

    // ------------------------------------------------------------------------
    // walk decisions
    // ------------------------------------------------------------------------
    assign accept   = cmd_valid && !cmd_stall;
    assign cur_in   = (cur_reg < END_MARK);
    assign less     = ($signed(key_q) < key_reg);
    assign advance  = cur_in && less && (steps_reg < STEP_W'(CAPACITY));
    assign hit      = cur_in && !less && (key_q == key_reg);
    assign out_free = !res_valid_reg || !res_stall;

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_REINIT)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (command == CMD_INSERT && free_head_reg >= END_MARK)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (!advance)
                begin
                    if (cmd_reg == CMD_INSERT && !hit)
                    begin
                        state_next = S_INS_LINK;
                    end
                    else if (cmd_reg == CMD_DELETE && hit)
                    begin
                        state_next = S_DEL_PREV;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_INS_LINK: state_next = S_INS_PREV;
            S_INS_PREV: state_next = S_RESULT;
            S_DEL_PREV: state_next = S_DEL_FREE;
            S_DEL_FREE: state_next = S_RESULT;
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // outputs and datapath
    // ------------------------------------------------------------------------
    always_comb
    begin
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        cur_link_next  = cur_link_reg;
        node_next      = node_reg;
        steps_next     = steps_reg;
        rstat_next     = rstat_reg;
        rslot_next     = rslot_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        res_valid_next = res_valid_reg && res_stall;

        rd_addr     = list_head_reg[IDX_W-1:0];
        lk_we       = 1'b0;
        ky_we       = 1'b0;
        wr_addr     = prev_reg[IDX_W-1:0];
        lk_wd       = cur_link_reg;
        clear_links = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = command;
                    key_next   = key;
                    cur_next   = list_head_reg;
                    prev_next  = END_MARK;
                    steps_next = '0;
                    rstat_next = ST_OK;
                    rslot_next = '0;
                    if (command == CMD_REINIT)
                    begin
                        clear_links    = 1'b1;
                        list_head_next = END_MARK;
                        free_head_next = '0;
                    end
                    else if (command == CMD_INSERT && free_head_reg >= END_MARK)
                    begin
                        rstat_next = ST_FULL;
                    end
                end
            end
            S_WALK:
            begin
                if (advance)
                begin
                    rd_addr    = link_eff[IDX_W-1:0];
                    prev_next  = cur_reg;
                    cur_next   = link_eff;
                    steps_next = steps_reg + STEP_W'(1);
                end
                else
                begin
                    rd_addr       = free_head_reg[IDX_W-1:0];
                    cur_link_next = link_eff;
                    case (cmd_reg)
                        CMD_SEARCH:
                        begin
                            rstat_next = hit ? ST_OK : ST_NOT_FOUND;
                            rslot_next = hit ? SLOT_W'(cur_reg[IDX_W-1:0]) : '0;
                        end
                        CMD_INSERT:
                        begin
                            if (hit)
                            begin
                                rstat_next = ST_DUPLICATE;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (!hit)
                            begin
                                rstat_next = ST_NOT_FOUND;
                            end
                        end
                        default: rstat_next = ST_OK;
                    endcase
                end
            end
            S_INS_LINK:
            begin
                // link_eff holds the link of the free head here
                wr_addr        = free_head_reg[IDX_W-1:0];
                lk_we          = 1'b1;
                ky_we          = 1'b1;
                lk_wd          = cur_reg;
                node_next      = free_head_reg[IDX_W-1:0];
                free_head_next = link_eff;
            end
            S_INS_PREV:
            begin
                if (prev_reg >= END_MARK)
                begin
                    list_head_next = LINK_W'({1'b0, node_reg});
                end
                else
                begin
                    lk_we   = 1'b1;
                    wr_addr = prev_reg[IDX_W-1:0];
                    lk_wd   = LINK_W'({1'b0, node_reg});
                end
                rstat_next = ST_OK;
                rslot_next = SLOT_W'(node_reg);
            end
            S_DEL_PREV:
            begin
                if (prev_reg >= END_MARK)
                begin
                    list_head_next = cur_link_reg;
                end
                else
                begin
                    lk_we   = 1'b1;
                    wr_addr = prev_reg[IDX_W-1:0];
                    lk_wd   = cur_link_reg;
                end
            end
            S_DEL_FREE:
            begin
                lk_we          = 1'b1;
                wr_addr        = cur_reg[IDX_W-1:0];
                lk_wd          = free_head_reg;
                free_head_next = cur_reg;
                rstat_next     = ST_OK;
                rslot_next     = SLOT_W'(cur_reg[IDX_W-1:0]);
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    status_next    = rstat_reg;
                    slot_next      = rslot_reg;
                end
            end
            default:
            begin
                rd_addr = list_head_reg[IDX_W-1:0];
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            list_head_reg <= END_MARK;
            free_head_reg <= '0;
            cur_reg       <= END_MARK;
            prev_reg      <= END_MARK;
            steps_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            steps_reg     <= steps_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        cur_link_reg <= cur_link_next;
        node_reg     <= node_next;
        rstat_reg    <= rstat_next;
        rslot_reg    <= rslot_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `SLLT_NEVER(a_no_write_in_walk, (state_reg == S_WALK) && (lk_we || ky_we), "write during walk")
    `SLLT_ASSERT(a_step_bound, steps_reg <= STEP_W'(CAPACITY), "walk step count overrun")
    `SLLT_ASSERT(a_fail_slot_zero, (res_valid_reg && status_reg != ST_OK) |-> (slot_reg == '0), "slot not zero on failure")
    `SLLT_ASSERT(a_load_from_result, $rose(res_valid_reg) |-> ($past(state_reg) == S_RESULT), "result loaded outside result state")

endmodule
